// File: rtl/cdl_pkg.sv
// ----------------------------------------------------------------------------
// cdl_pkg
// Shared constants, payload structs and controller/datapath command types
// for the circular doubly linked list engine.
// ----------------------------------------------------------------------------
package cdl_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int LINK_W     = $clog2(CAPACITY + 1);
    localparam int VALUE_W    = 32;
    localparam int ELEMENT_W  = 32;
    localparam int COUNT_W    = 7;

    typedef enum logic [1:0] {
        CMD_INSERT   = 2'd0,
        CMD_DELETE   = 2'd1,
        CMD_WALK_FWD = 2'd2,
        CMD_WALK_BWD = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_INSERT  = 2'd0,
        KIND_DELETE  = 2'd1,
        KIND_ELEMENT = 2'd2,
        KIND_EMPTY   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        RD_HEAD,
        RD_TAIL,
        RD_NEXT,
        RD_PREV
    } rd_sel_t;

    typedef struct packed {
        cmd_t                 cmd;
        logic [VALUE_W-1:0]   value;
    } req_t;

    typedef struct packed {
        kind_t                kind;
        logic                 ok;
        logic [ELEMENT_W-1:0] element;
        logic                 last;
        logic [COUNT_W-1:0]   count;
    } rsp_t;

    typedef struct packed {
        logic    load_value;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    fs_read;
        logic    ins_write;
        logic    ins_link;
        logic    del_unlink_next;
        logic    del_unlink_prev;
        logic    step_clr;
        logic    step_inc;
        logic    out_load;
        kind_t   out_kind;
        logic    out_ok;
        logic    out_last;
        logic    out_elem;
    } dp_cmd_t;

    typedef struct packed {
        logic head_sent;
        logic tail_sent;
        logic pool_empty;
        logic match;
        logic next_sent;
        logic prev_sent;
        logic steps_last;
        logic out_free;
    } dp_stat_t;

endpackage

// File: rtl/cdl_dp.sv
// ----------------------------------------------------------------------------
// cdl_dp
// Datapath: node pool memories, free stack, list pointers, step counter and
// the result register.
// ----------------------------------------------------------------------------
module cdl_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cdl_pkg::dp_cmd_t           cmd,
    output cdl_pkg::dp_stat_t          stat,
    input  logic [cdl_pkg::VALUE_W-1:0] value,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output cdl_pkg::rsp_t              rsp
);
    import cdl_pkg::*;

    localparam logic [LINK_W-1:0] SENT = LINK_W'(CAPACITY);

    function automatic logic is_sent(input logic [LINK_W-1:0] x);
        return x >= SENT;
    endfunction

    logic [DATA_WIDTH-1:0] data_mem [CAPACITY];
    logic [LINK_W-1:0]     next_mem [CAPACITY];
    logic [LINK_W-1:0]     prev_mem [CAPACITY];
    logic [IDX_W-1:0]      fs_mem   [CAPACITY];

    logic [CAPACITY-1:0]   fs_valid_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [LINK_W-1:0]     head_reg, tail_reg, free_top_reg, count_reg;
    logic [IDX_W-1:0]      cur_reg, node_reg, step_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [LINK_W-1:0]     rd_next_reg, rd_prev_reg;
    logic [IDX_W-1:0]      fs_rd_reg, fs_addr_reg;
    logic                  fs_hit_reg;
    logic                  out_valid_reg;
    rsp_t                  rsp_reg;

    logic [LINK_W-1:0]     rd_link;
    logic [IDX_W-1:0]      rd_addr, fs_pop_addr, fs_push_addr, new_node;
    logic                  prev_we;
    logic [IDX_W-1:0]      prev_waddr;
    logic [LINK_W-1:0]     prev_wdata;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_HEAD: rd_link = head_reg;
            RD_TAIL: rd_link = tail_reg;
            RD_NEXT: rd_link = rd_next_reg;
            default: rd_link = rd_prev_reg;
        endcase
    end

    assign rd_addr      = rd_link[IDX_W-1:0];
    assign fs_pop_addr  = IDX_W'(free_top_reg - 1'b1);
    assign fs_push_addr = free_top_reg[IDX_W-1:0];
    assign new_node     = fs_hit_reg ? fs_rd_reg : fs_addr_reg;

    // prev links are written by insert (new node, old head) and delete
    always_comb
    begin
        prev_we    = 1'b0;
        prev_waddr = new_node;
        prev_wdata = SENT;
        if (cmd.ins_write)
        begin
            prev_we = 1'b1;
        end
        else if (cmd.ins_link && !is_sent(head_reg))
        begin
            prev_we    = 1'b1;
            prev_waddr = head_reg[IDX_W-1:0];
            prev_wdata = LINK_W'(node_reg);
        end
        else if (cmd.del_unlink_prev && !is_sent(rd_next_reg))
        begin
            prev_we    = 1'b1;
            prev_waddr = rd_next_reg[IDX_W-1:0];
            prev_wdata = rd_prev_reg;
        end
    end

    // memories and read data
    always_ff @(posedge clk)
    begin
        if (cmd.ins_write)
        begin
            data_mem[new_node] <= value_reg;
            next_mem[new_node] <= head_reg;
        end
        else if (cmd.del_unlink_next && !is_sent(rd_prev_reg))
        begin
            next_mem[rd_prev_reg[IDX_W-1:0]] <= rd_next_reg;
        end
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (cmd.del_unlink_prev && (free_top_reg < SENT))
        begin
            fs_mem[fs_push_addr] <= cur_reg;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= data_mem[rd_addr];
            rd_next_reg <= next_mem[rd_addr];
            rd_prev_reg <= prev_mem[rd_addr];
        end
        if (cmd.fs_read)
        begin
            fs_rd_reg   <= fs_mem[fs_pop_addr];
            fs_addr_reg <= fs_pop_addr;
        end
        if (cmd.load_value)
        begin
            value_reg <= DATA_WIDTH'(value);
        end
        if (cmd.ins_write)
        begin
            node_reg <= new_node;
        end
        if (cmd.out_load)
        begin
            rsp_reg.kind    <= cmd.out_kind;
            rsp_reg.ok      <= cmd.out_ok;
            rsp_reg.element <= cmd.out_elem ? ELEMENT_W'(rd_data_reg) : '0;
            rsp_reg.last    <= cmd.out_last;
            rsp_reg.count   <= COUNT_W'(count_reg);
        end
    end

    // list pointers and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_valid_reg  <= '0;
            fs_hit_reg    <= 1'b0;
            head_reg      <= SENT;
            tail_reg      <= SENT;
            free_top_reg  <= SENT;
            count_reg     <= '0;
            cur_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // unwritten free stack slots hold their own index
            if (cmd.fs_read)
            begin
                fs_hit_reg <= fs_valid_reg[fs_pop_addr];
            end
            if (cmd.rd_en)
            begin
                cur_reg <= rd_addr;
            end
            if (cmd.step_clr)
            begin
                step_reg <= '0;
            end
            else if (cmd.step_inc)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (cmd.ins_link)
            begin
                head_reg     <= LINK_W'(node_reg);
                count_reg    <= count_reg + 1'b1;
                free_top_reg <= free_top_reg - 1'b1;
                if (is_sent(head_reg))
                begin
                    tail_reg <= LINK_W'(node_reg);
                end
            end
            if (cmd.del_unlink_next && is_sent(rd_prev_reg))
            begin
                head_reg <= rd_next_reg;
            end
            if (cmd.del_unlink_prev)
            begin
                if (is_sent(rd_next_reg))
                begin
                    tail_reg <= rd_prev_reg;
                end
                if (free_top_reg < SENT)
                begin
                    fs_valid_reg[fs_push_addr] <= 1'b1;
                    free_top_reg               <= free_top_reg + 1'b1;
                end
                if (count_reg != '0)
                begin
                    count_reg <= count_reg - 1'b1;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.head_sent  = is_sent(head_reg);
    assign stat.tail_sent  = is_sent(tail_reg);
    assign stat.pool_empty = (free_top_reg == '0);
    assign stat.match      = (rd_data_reg == value_reg);
    assign stat.next_sent  = is_sent(rd_next_reg);
    assign stat.prev_sent  = is_sent(rd_prev_reg);
    assign stat.steps_last = (step_reg == IDX_W'(CAPACITY - 1));
    assign stat.out_free   = !out_valid_reg || !rsp_stall;

    assign rsp_valid = out_valid_reg;
    assign rsp       = rsp_reg;

    // every node is either on the list or on the free stack
    a_pool_balance: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, count_reg} + {1'b0, free_top_reg}) == (LINK_W + 1)'(CAPACITY))
        else $error("list count and free stack depth disagree");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SENT)
        else $error("list count above capacity");

    a_tail_empty: assert property (@(posedge clk) disable iff (!rst_n)
        is_sent(tail_reg) == (count_reg == '0))
        else $error("tail pointer out of step with list count");

endmodule

// File: rtl/cdl_ctrl.sv
// ----------------------------------------------------------------------------
// cdl_ctrl
// Controller: sequences insert, search/unlink and walks over the datapath.
// ----------------------------------------------------------------------------
module cdl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  cdl_pkg::cmd_t     req_cmd,
    output logic              req_stall,
    input  cdl_pkg::dp_stat_t stat,
    output cdl_pkg::dp_cmd_t  dp_cmd
);
    import cdl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_WRITE,
        S_INS_LINK,
        S_DEL_CMP,
        S_DEL_UNLINK_N,
        S_DEL_UNLINK_P,
        S_WALK,
        S_RESP
    } state_t;

    state_t state_reg, state_next;
    kind_t  kind_reg, kind_next;
    logic   ok_reg, ok_next;
    logic   fwd_reg, fwd_next;
    logic   walk_end;

    assign walk_end = (fwd_reg ? stat.next_sent : stat.prev_sent) || stat.steps_last;

    always_comb
    begin
        dp_cmd     = '0;
        state_next = state_reg;
        kind_next  = kind_reg;
        ok_next    = ok_reg;
        fwd_next   = fwd_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    dp_cmd.load_value = 1'b1;
                    ok_next           = 1'b0;
                    unique case (req_cmd)
                        CMD_INSERT:
                        begin
                            kind_next = KIND_INSERT;
                            if (stat.pool_empty)
                            begin
                                state_next = S_RESP;
                            end
                            else
                            begin
                                dp_cmd.fs_read = 1'b1;
                                state_next     = S_INS_WRITE;
                            end
                        end
                        CMD_DELETE:
                        begin
                            kind_next = KIND_DELETE;
                            if (stat.head_sent)
                            begin
                                state_next = S_RESP;
                            end
                            else
                            begin
                                dp_cmd.rd_en    = 1'b1;
                                dp_cmd.rd_sel   = RD_HEAD;
                                dp_cmd.step_clr = 1'b1;
                                state_next      = S_DEL_CMP;
                            end
                        end
                        CMD_WALK_FWD:
                        begin
                            fwd_next = 1'b1;
                            if (stat.head_sent)
                            begin
                                kind_next  = KIND_EMPTY;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                dp_cmd.rd_en    = 1'b1;
                                dp_cmd.rd_sel   = RD_HEAD;
                                dp_cmd.step_clr = 1'b1;
                                state_next      = S_WALK;
                            end
                        end
                        default:
                        begin
                            fwd_next = 1'b0;
                            if (stat.tail_sent)
                            begin
                                kind_next  = KIND_EMPTY;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                dp_cmd.rd_en    = 1'b1;
                                dp_cmd.rd_sel   = RD_TAIL;
                                dp_cmd.step_clr = 1'b1;
                                state_next      = S_WALK;
                            end
                        end
                    endcase
                end
            end
            S_INS_WRITE:
            begin
                dp_cmd.ins_write = 1'b1;
                state_next       = S_INS_LINK;
            end
            S_INS_LINK:
            begin
                dp_cmd.ins_link = 1'b1;
                ok_next         = 1'b1;
                state_next      = S_RESP;
            end
            S_DEL_CMP:
            begin
                if (stat.match)
                begin
                    state_next = S_DEL_UNLINK_N;
                end
                else if (stat.next_sent || stat.steps_last)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    dp_cmd.rd_en    = 1'b1;
                    dp_cmd.rd_sel   = RD_NEXT;
                    dp_cmd.step_inc = 1'b1;
                end
            end
            S_DEL_UNLINK_N:
            begin
                dp_cmd.del_unlink_next = 1'b1;
                state_next             = S_DEL_UNLINK_P;
            end
            S_DEL_UNLINK_P:
            begin
                dp_cmd.del_unlink_prev = 1'b1;
                ok_next                = 1'b1;
                state_next             = S_RESP;
            end
            S_WALK:
            begin
                if (stat.out_free)
                begin
                    dp_cmd.out_load = 1'b1;
                    dp_cmd.out_kind = KIND_ELEMENT;
                    dp_cmd.out_elem = 1'b1;
                    dp_cmd.out_last = walk_end;
                    if (walk_end)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        dp_cmd.rd_en    = 1'b1;
                        dp_cmd.rd_sel   = fwd_reg ? RD_NEXT : RD_PREV;
                        dp_cmd.step_inc = 1'b1;
                    end
                end
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    dp_cmd.out_load = 1'b1;
                    dp_cmd.out_kind = kind_reg;
                    dp_cmd.out_ok   = ok_reg;
                    dp_cmd.out_last = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= KIND_INSERT;
            ok_reg    <= 1'b0;
            fwd_reg   <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            ok_reg    <= ok_next;
            fwd_reg   <= fwd_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

endmodule

// File: rtl/circular_doubly_linked_list_engine.sv
// ----------------------------------------------------------------------------
// circular_doubly_linked_list_engine
// Bounded doubly linked list of data words in a 64-node pool with a free
// stack; insert at head, delete first match, forward and backward walks.
// ----------------------------------------------------------------------------
// Sequence: insert pops the free stack, writes and links the node, then answers; a full
//   pool answers directly. Delete compares up to 64 nodes, then unlinks on a match.
// Walks: the head or tail node is read on accept, then one beat per cycle while the
//   result register drains; an empty walk gives one beat.
// Throughput: one item at a time; next command accepted the cycle after the last beat loads.
// Reset (async, active low): list empty, all nodes free; no clearing pass.
// ----------------------------------------------------------------------------
module circular_doubly_linked_list_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  cdl_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output cdl_pkg::rsp_t  rsp
);
    import cdl_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // controller: one state per memory access, stalls input while busy
    cdl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_cmd   (req.cmd),
        .req_stall (req_stall),
        .stat      (dp_stat),
        .dp_cmd    (dp_cmd)
    );

    // datapath: node pool, free stack, pointers and the result register;
    // the result register frees itself when a beat is taken, so the walk
    // advances in the same cycle a stalled beat drains
    cdl_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .value     (req.value),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the circular doubly linked list engine: a local
// model of the node pool predicts every response beat, a scoreboard class
// matches them in order, and random idling is applied on both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import cdl_pkg::*;

    // Expected-beat store and checker
    class list_scoreboard;
        rsp_t expected_q[$];
        int   mismatches;
        int   beats_seen;

        // model state: list kept head first, pool index bookkeeping not needed
        // since only values and order are observable
        logic [DATA_WIDTH-1:0] contents[$];

        function void note_request(req_t r);
            rsp_t b;
            int   hit;
            b = '0;
            b.last = 1'b1;
            case (r.cmd)
                CMD_INSERT:
                begin
                    b.kind = KIND_INSERT;
                    if (contents.size() < CAPACITY)
                    begin
                        contents.push_front(r.value[DATA_WIDTH-1:0]);
                        b.ok = 1'b1;
                    end
                    b.count = COUNT_W'(contents.size());
                    expected_q.push_back(b);
                end
                CMD_DELETE:
                begin
                    b.kind = KIND_DELETE;
                    hit = -1;
                    foreach (contents[i])
                        if (hit < 0 && contents[i] == r.value[DATA_WIDTH-1:0])
                            hit = i;
                    if (hit >= 0)
                    begin
                        contents.delete(hit);
                        b.ok = 1'b1;
                    end
                    b.count = COUNT_W'(contents.size());
                    expected_q.push_back(b);
                end
                default:
                begin
                    b.count = COUNT_W'(contents.size());
                    if (contents.size() == 0)
                    begin
                        b.kind = KIND_EMPTY;
                        expected_q.push_back(b);
                    end
                    else
                    begin
                        b.kind = KIND_ELEMENT;
                        for (int i = 0; i < contents.size(); i++)
                        begin
                            b.element = (r.cmd == CMD_WALK_FWD) ?
                                contents[i] : contents[contents.size()-1-i];
                            b.last = (i == contents.size() - 1);
                            expected_q.push_back(b);
                        end
                    end
                end
            endcase
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            beats_seen++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: %p", got);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    list_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  idle_cycles;
    int  items_sent;
    logic [DATA_WIDTH-1:0] recent_values[$];

    circular_doubly_linked_list_engine u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Response side: stall at random, check every accepted beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                sb.check_response(rsp);
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("TEST FAILED");
            $finish;
        end
    end

    // Drive one request beat and hold until accepted; random gap first.
    // Valid stays high into the next call unless a gap is taken.
    task automatic send_request(input cmd_t c, input logic [VALUE_W-1:0] v);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        req_valid <= 1'b1;
        req.cmd   <= c;
        req.value <= v;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request('{cmd: c, value: v});
        items_sent++;
        if (c == CMD_INSERT)
            recent_values.push_back(v);
    endtask

    task automatic drain;
        req_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // Random mix: inserts are the most common request; deletes often hit
    task automatic random_items(input int n);
        int pick;
        logic [VALUE_W-1:0] v;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            v = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom;
            if (pick < 45)
                send_request(CMD_INSERT, v);
            else if (pick < 75)
            begin
                if (recent_values.size() != 0 && $urandom_range(2) != 0)
                    v = recent_values[$urandom_range(recent_values.size()-1)];
                send_request(CMD_DELETE, v);
            end
            else if (pick < 88)
                send_request(CMD_WALK_FWD, v);
            else
                send_request(CMD_WALK_BWD, v);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        idle_cycles = 0;
        items_sent = 0;
        send_idle_pct = 21;
        recv_idle_pct = 72;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty walks, empty delete, extremes, duplicates
        send_request(CMD_WALK_FWD, '0);
        send_request(CMD_WALK_BWD, '1);
        send_request(CMD_DELETE, 32'h0);
        send_request(CMD_INSERT, 32'hFFFF_FFFF);
        send_request(CMD_INSERT, 32'h0);
        send_request(CMD_INSERT, 32'h5555_AAAA);
        send_request(CMD_INSERT, 32'h0);
        send_request(CMD_WALK_FWD, 32'h0);
        send_request(CMD_WALK_BWD, 32'h0);
        send_request(CMD_DELETE, 32'h0);       // removes the one nearest head
        send_request(CMD_DELETE, 32'h1234_5678); // no match
        send_request(CMD_WALK_FWD, 32'hAAAA_5555);
        send_request(CMD_DELETE, 32'hFFFF_FFFF); // tail removal
        send_request(CMD_DELETE, 32'h0);
        send_request(CMD_DELETE, 32'h5555_AAAA); // back to empty
        send_request(CMD_WALK_BWD, 32'h0);
        drain();  // sender holds off until every beat is back

        // Fill the pool, overflow, walk both ways
        for (int i = 0; i < CAPACITY + 2; i++)
            send_request(CMD_INSERT, $urandom);
        send_request(CMD_WALK_FWD, 32'h0);
        send_request(CMD_WALK_BWD, 32'h0);

        // Random phases: swapped idling, then none
        send_idle_pct = 72;
        recv_idle_pct = 21;
        random_items(23);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_items(23);
        drain();

        $display("ran %0d requests, %0d response beats; full pool and empty walks included",
                 items_sent, sb.beats_seen);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d mismatches, %0d beats missing", sb.mismatches, sb.expected_q.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: circular_doubly_linked_list_engine.f
rtl/cdl_pkg.sv
rtl/cdl_dp.sv
rtl/cdl_ctrl.sv
rtl/circular_doubly_linked_list_engine.sv
sim/tb_top.sv
